// ===== hdl/vsv_pkg.sv =====
package vsv_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_AMOUNT      = 3'd0;
  localparam logic [2:0] REG_TIME        = 3'd1;
  localparam logic [2:0] REG_SHARP       = 3'd2;
  localparam logic [2:0] REG_MIN_SPEED   = 3'd3;
  localparam logic [2:0] REG_MAX_STRETCH = 3'd4;

  // Register reset values, Q16.16
  localparam logic [19:0] AMOUNT_RST      = 20'd65536;
  localparam logic [17:0] TIME_RST        = 18'd5243;
  localparam logic [20:0] SHARP_RST       = 21'd98304;
  localparam logic [23:0] MIN_SPEED_RST   = 24'd131072;
  localparam logic [22:0] MAX_STRETCH_RST = 23'd196608;

  localparam logic [20:0] SHARP_FLOOR = 21'd3277;
  localparam logic [23:0] HALF_Q16    = 24'd32768;
  localparam logic [16:0] ONE_Q16     = 17'd65536;
  localparam logic [17:0] THREE_Q16   = 18'd196608;

  // Square root chain: 32 cells, one result bit each
  localparam int unsigned SQRT_CELLS = 32;
  // Fade divider: 16 quotient bits; rescale divider: 23 quotient bits
  localparam int unsigned DIV1_CELLS = 16;
  localparam int unsigned DIV2_CELLS = 23;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] dvs;
    logic [22:0] quo;
  } div_t;

  // Payload that travels alongside the arithmetic chains
  typedef struct packed {
    logic             hv;
    logic [2:0]       pos;
    logic [2:0][24:0] mag;
    logic             zero;
    logic             full;
    logic [16:0]      x;
    logic [16:0]      fade;
    logic [22:0]      gn;
    logic [2:0][30:0] m;
    logic             rsc;
  } pipe_t;

endpackage

// ===== hdl/vsv_sqrt_cell.sv =====
module vsv_sqrt_cell (
  input  logic           clk,
  input  logic           en,
  input  logic [4:0]     step,
  input  vsv_pkg::sqrt_t din,
  output vsv_pkg::sqrt_t dout
);

  logic [63:0]    bitv;
  logic [63:0]    trial;
  vsv_pkg::sqrt_t q_nxt;
  vsv_pkg::sqrt_t q_r;

  // One digit of the digit-by-digit root: test the bit at 4^step
  always_comb begin
    bitv  = 64'd1 << {step, 1'b0};
    trial = din.root + bitv;
    if (din.rem >= trial) begin
      q_nxt.rem  = din.rem - trial;
      q_nxt.root = (din.root >> 1) + bitv;
    end else begin
      q_nxt.rem  = din.rem;
      q_nxt.root = din.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign dout = q_r;

endmodule

// ===== hdl/vsv_div_cell.sv =====
module vsv_div_cell (
  input  logic          clk,
  input  logic          en,
  input  logic [4:0]    shift,
  input  vsv_pkg::div_t din,
  output vsv_pkg::div_t dout
);

  logic [63:0]   trial;
  vsv_pkg::div_t q_nxt;
  vsv_pkg::div_t q_r;

  // One restoring step: subtract the divisor at this bit weight if it fits
  always_comb begin
    trial     = {32'd0, din.dvs} << shift;
    q_nxt.dvs = din.dvs;
    if (din.rem >= trial) begin
      q_nxt.rem = din.rem - trial;
      q_nxt.quo = {din.quo[21:0], 1'b1};
    end else begin
      q_nxt.rem = din.rem;
      q_nxt.quo = {din.quo[21:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign dout = q_r;

endmodule

// ===== hdl/velocity_smear_vector_top.sv =====
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | velocity_valid, vel_x, vel_y, vel_z
// out     | output    | out_valid/out_stall| has_smear, smear_x/y/z, sharpness_out
// cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_wdata
//
// One transaction enters per cycle while in_stall is low; the pipeline holds two
// 32-cell square root chains, a 16-cell and a 23-cell divider chain.
// Reset (rst_n low, synchronous) clears all valid bits and reloads the
// configuration registers with their defaults; no clearing pass.
// The whole row advances together: a stalled output holds every cell and
// in_stall rises in the same cycle. cfg_ready is always high.
module velocity_smear_vector_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_velocity_valid,
  input  logic signed [24:0] in_vel_x,
  input  logic signed [24:0] in_vel_y,
  input  logic signed [24:0] in_vel_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_has_smear,
  output logic signed [23:0] out_smear_x,
  output logic signed [23:0] out_smear_y,
  output logic signed [23:0] out_smear_z,
  output logic        [20:0] out_sharpness_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [2:0]  cfg_index,
  input  logic        [23:0] cfg_wdata
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [19:0] amount_r;
  logic [17:0] time_r;
  logic [20:0] sharp_r;
  logic [23:0] min_speed_r;
  logic [22:0] max_stretch_r;
  logic [21:0] tg_r;       // smear_time * amount_gain, Q16.16
  logic [37:0] tg_prod;
  logic [23:0] band;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amount_r      <= vsv_pkg::AMOUNT_RST;
      time_r        <= vsv_pkg::TIME_RST;
      sharp_r       <= vsv_pkg::SHARP_RST;
      min_speed_r   <= vsv_pkg::MIN_SPEED_RST;
      max_stretch_r <= vsv_pkg::MAX_STRETCH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        vsv_pkg::REG_AMOUNT:      amount_r      <= cfg_wdata[19:0];
        vsv_pkg::REG_TIME:        time_r        <= cfg_wdata[17:0];
        vsv_pkg::REG_SHARP:       sharp_r       <= cfg_wdata[20:0];
        vsv_pkg::REG_MIN_SPEED:   min_speed_r   <= cfg_wdata;
        vsv_pkg::REG_MAX_STRETCH: max_stretch_r <= cfg_wdata[22:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // The gain product only changes with configuration, so precompute it
  assign tg_prod = 38'(time_r) * 38'(amount_r);
  always_ff @(posedge clk) begin
    tg_r <= tg_prod[37:16];
  end

  // Fade band width: max(min_speed, 0.5)
  assign band = (min_speed_r > vsv_pkg::HALF_Q16) ? min_speed_r : vsv_pkg::HALF_Q16;

  // ---------------------------------------------------------------------
  // Flow control: every stage moves when the output register can move
  // ---------------------------------------------------------------------
  logic adv;
  logic out_vld_r;

  assign adv      = !out_vld_r || !out_stall;
  assign in_stall = !adv;

  // ---------------------------------------------------------------------
  // Stage a: split the components into magnitude and sign
  // ---------------------------------------------------------------------
  logic                a_v_r;
  vsv_pkg::pipe_t      a_p_r;
  vsv_pkg::pipe_t      a_p_nxt;
  logic [2:0][24:0]    in_raw;
  logic [2:0][24:0]    in_mag;
  logic [2:0]          in_pos;

  assign in_raw = {in_vel_z, in_vel_y, in_vel_x};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_mag[k] = in_raw[k][24] ? (~in_raw[k] + 25'd1) : in_raw[k];
      in_pos[k] = !in_raw[k][24] && (in_raw[k] != 25'd0);
    end
  end

  always_comb begin
    a_p_nxt     = '0;
    a_p_nxt.hv  = in_velocity_valid;
    a_p_nxt.mag = in_mag;
    a_p_nxt.pos = in_pos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_p_r <= a_p_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stages b, c: squares, then their sum
  // ---------------------------------------------------------------------
  logic             b_v_r;
  vsv_pkg::pipe_t   b_p_r;
  logic [2:0][48:0] b_sq_r;
  logic             c_v_r;
  vsv_pkg::pipe_t   c_p_r;
  logic [50:0]      c_sum_r;
  logic [2:0][49:0] a_sq;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      a_sq[k] = 50'(a_p_r.mag[k]) * 50'(a_p_r.mag[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else if (adv) begin
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_p_r <= a_p_r;
      for (int k = 0; k < 3; k++) begin
        b_sq_r[k] <= a_sq[k][48:0];
      end
      c_p_r   <= b_p_r;
      c_sum_r <= 51'(b_sq_r[0]) + 51'(b_sq_r[1]) + 51'(b_sq_r[2]);
    end
  end

  // ---------------------------------------------------------------------
  // Speed: square root chain
  // ---------------------------------------------------------------------
  vsv_pkg::sqrt_t sq1_s [0:vsv_pkg::SQRT_CELLS];
  vsv_pkg::pipe_t sq1_p [0:vsv_pkg::SQRT_CELLS];
  logic           sq1_v [0:vsv_pkg::SQRT_CELLS];

  assign sq1_s[0] = '{rem: 64'(c_sum_r), root: 64'd0};
  assign sq1_p[0] = c_p_r;
  assign sq1_v[0] = c_v_r;

  for (genvar gi = 0; gi < vsv_pkg::SQRT_CELLS; gi++) begin : g_sq1
    vsv_sqrt_cell u_cell (
      .clk  (clk),
      .en   (adv),
      .step (5'(vsv_pkg::SQRT_CELLS - 1 - gi)),
      .din  (sq1_s[gi]),
      .dout (sq1_s[gi+1])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq1_v[gi+1] <= 1'b0;
      end else if (adv) begin
        sq1_v[gi+1] <= sq1_v[gi];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq1_p[gi+1] <= sq1_p[gi];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage d: place speed in the fade band, feed the divider
  // ---------------------------------------------------------------------
  logic [31:0]    speed;
  logic [31:0]    diff;
  logic           d_v_r;
  vsv_pkg::pipe_t d_p_r;
  vsv_pkg::pipe_t d_p_nxt;
  vsv_pkg::div_t  d_div_r;

  assign speed = sq1_s[vsv_pkg::SQRT_CELLS].root[31:0];
  assign diff  = speed - {8'd0, min_speed_r};

  always_comb begin
    d_p_nxt      = sq1_p[vsv_pkg::SQRT_CELLS];
    d_p_nxt.zero = speed <= {8'd0, min_speed_r};
    d_p_nxt.full = diff >= {8'd0, band};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (adv) begin
      d_v_r <= sq1_v[vsv_pkg::SQRT_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_p_r   <= d_p_nxt;
      d_div_r <= '{rem: {16'd0, diff, 16'd0}, dvs: {8'd0, band}, quo: 23'd0};
    end
  end

  // ---------------------------------------------------------------------
  // Fade position: (speed - min_speed) / band, 16 quotient bits
  // ---------------------------------------------------------------------
  vsv_pkg::div_t  dv1_s [0:vsv_pkg::DIV1_CELLS];
  vsv_pkg::pipe_t dv1_p [0:vsv_pkg::DIV1_CELLS];
  logic           dv1_v [0:vsv_pkg::DIV1_CELLS];

  assign dv1_s[0] = d_div_r;
  assign dv1_p[0] = d_p_r;
  assign dv1_v[0] = d_v_r;

  for (genvar gi = 0; gi < vsv_pkg::DIV1_CELLS; gi++) begin : g_dv1
    vsv_div_cell u_cell (
      .clk   (clk),
      .en    (adv),
      .shift (5'(vsv_pkg::DIV1_CELLS - 1 - gi)),
      .din   (dv1_s[gi]),
      .dout  (dv1_s[gi+1])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv1_v[gi+1] <= 1'b0;
      end else if (adv) begin
        dv1_v[gi+1] <= dv1_v[gi];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv1_p[gi+1] <= dv1_p[gi];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stages e..i: fade position, smoothstep, gain, scaled magnitudes
  // ---------------------------------------------------------------------
  vsv_pkg::pipe_t   dv1_out;
  logic [15:0]      dv1_quo;
  logic             e_v_r, f_v_r, g_v_r, h_v_r, i_v_r;
  vsv_pkg::pipe_t   e_p_r, f_p_r, g_p_r, h_p_r, i_p_r;
  vsv_pkg::pipe_t   e_p_nxt, g_p_nxt, h_p_nxt, i_p_nxt;
  logic [16:0]      f_xx_r;
  logic [33:0]      xx_prod;
  logic [17:0]      poly;
  logic [34:0]      fade_prod;
  logic [38:0]      gn_prod;
  logic [2:0][47:0] m_prod;

  assign dv1_out = dv1_p[vsv_pkg::DIV1_CELLS];
  assign dv1_quo = dv1_s[vsv_pkg::DIV1_CELLS].quo[15:0];

  assign xx_prod   = 34'(e_p_r.x) * 34'(e_p_r.x);
  assign poly      = vsv_pkg::THREE_Q16 - {f_p_r.x, 1'b0};
  assign fade_prod = 35'(f_xx_r) * 35'(poly);
  assign gn_prod   = 39'(tg_r) * 39'(g_p_r.fade);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m_prod[k] = 48'(h_p_r.mag[k]) * 48'(h_p_r.gn);
    end
  end

  always_comb begin
    e_p_nxt = dv1_out;
    if (dv1_out.zero) begin
      e_p_nxt.x = 17'd0;
    end else if (dv1_out.full) begin
      e_p_nxt.x = vsv_pkg::ONE_Q16;
    end else begin
      e_p_nxt.x = {1'b0, dv1_quo};
    end
    g_p_nxt      = f_p_r;
    g_p_nxt.fade = fade_prod[32:16];
    h_p_nxt      = g_p_r;
    h_p_nxt.gn   = gn_prod[38:16];
    i_p_nxt      = h_p_r;
    for (int k = 0; k < 3; k++) begin
      i_p_nxt.m[k] = m_prod[k][46:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
      g_v_r <= 1'b0;
      h_v_r <= 1'b0;
      i_v_r <= 1'b0;
    end else if (adv) begin
      e_v_r <= dv1_v[vsv_pkg::DIV1_CELLS];
      f_v_r <= e_v_r;
      g_v_r <= f_v_r;
      h_v_r <= g_v_r;
      i_v_r <= h_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_p_r  <= e_p_nxt;
      f_p_r  <= e_p_r;
      f_xx_r <= xx_prod[32:16];
      g_p_r  <= g_p_nxt;
      h_p_r  <= h_p_nxt;
      i_p_r  <= i_p_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stages j, k: smear length squared
  // ---------------------------------------------------------------------
  logic             j_v_r, k_v_r;
  vsv_pkg::pipe_t   j_p_r, k_p_r;
  logic [2:0][61:0] j_sq_r;
  logic [63:0]      k_sum_r;
  logic [2:0][61:0] i_sq;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      i_sq[k] = 62'(i_p_r.m[k]) * 62'(i_p_r.m[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_v_r <= 1'b0;
      k_v_r <= 1'b0;
    end else if (adv) begin
      j_v_r <= i_v_r;
      k_v_r <= j_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      j_p_r   <= i_p_r;
      j_sq_r  <= i_sq;
      k_p_r   <= j_p_r;
      k_sum_r <= 64'(j_sq_r[0]) + 64'(j_sq_r[1]) + 64'(j_sq_r[2]);
    end
  end

  // ---------------------------------------------------------------------
  // Smear length: second square root chain
  // ---------------------------------------------------------------------
  vsv_pkg::sqrt_t sq2_s [0:vsv_pkg::SQRT_CELLS];
  vsv_pkg::pipe_t sq2_p [0:vsv_pkg::SQRT_CELLS];
  logic           sq2_v [0:vsv_pkg::SQRT_CELLS];

  assign sq2_s[0] = '{rem: k_sum_r, root: 64'd0};
  assign sq2_p[0] = k_p_r;
  assign sq2_v[0] = k_v_r;

  for (genvar gi = 0; gi < vsv_pkg::SQRT_CELLS; gi++) begin : g_sq2
    vsv_sqrt_cell u_cell (
      .clk  (clk),
      .en   (adv),
      .step (5'(vsv_pkg::SQRT_CELLS - 1 - gi)),
      .din  (sq2_s[gi]),
      .dout (sq2_s[gi+1])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq2_v[gi+1] <= 1'b0;
      end else if (adv) begin
        sq2_v[gi+1] <= sq2_v[gi];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq2_p[gi+1] <= sq2_p[gi];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage l: clamp decision and rescale products
  // ---------------------------------------------------------------------
  logic [31:0]          len;
  vsv_pkg::pipe_t       sq2_out;
  logic                 l_v_r;
  vsv_pkg::pipe_t       l_p_r;
  vsv_pkg::pipe_t       l_p_nxt;
  vsv_pkg::div_t [2:0]  l_div_r;
  logic [2:0][53:0]     rs_prod;

  assign len     = sq2_s[vsv_pkg::SQRT_CELLS].root[31:0];
  assign sq2_out = sq2_p[vsv_pkg::SQRT_CELLS];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rs_prod[k] = 54'(sq2_out.m[k]) * 54'(max_stretch_r);
    end
  end

  always_comb begin
    l_p_nxt     = sq2_out;
    l_p_nxt.rsc = len > {9'd0, max_stretch_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_v_r <= 1'b0;
    end else if (adv) begin
      l_v_r <= sq2_v[vsv_pkg::SQRT_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l_p_r <= l_p_nxt;
      for (int k = 0; k < 3; k++) begin
        l_div_r[k] <= '{rem: 64'(rs_prod[k]), dvs: len, quo: 23'd0};
      end
    end
  end

  // ---------------------------------------------------------------------
  // Rescale: three divider lanes, 23 quotient bits
  // ---------------------------------------------------------------------
  vsv_pkg::div_t [2:0] dv2_s [0:vsv_pkg::DIV2_CELLS];
  vsv_pkg::pipe_t      dv2_p [0:vsv_pkg::DIV2_CELLS];
  logic                dv2_v [0:vsv_pkg::DIV2_CELLS];

  assign dv2_s[0] = l_div_r;
  assign dv2_p[0] = l_p_r;
  assign dv2_v[0] = l_v_r;

  for (genvar gi = 0; gi < vsv_pkg::DIV2_CELLS; gi++) begin : g_dv2
    for (genvar gl = 0; gl < 3; gl++) begin : g_lane
      vsv_div_cell u_cell (
        .clk   (clk),
        .en    (adv),
        .shift (5'(vsv_pkg::DIV2_CELLS - 1 - gi)),
        .din   (dv2_s[gi][gl]),
        .dout  (dv2_s[gi+1][gl])
      );
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv2_v[gi+1] <= 1'b0;
      end else if (adv) begin
        dv2_v[gi+1] <= dv2_v[gi];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv2_p[gi+1] <= dv2_p[gi];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register: pick clamped or plain magnitude, point it backward
  // ---------------------------------------------------------------------
  vsv_pkg::pipe_t   fin;
  logic [2:0][23:0] mm;
  logic [2:0][23:0] smear;
  logic [20:0]      sharp_fl;
  logic             has_r;
  logic [2:0][23:0] smear_r;
  logic [20:0]      sharp_out_r;

  assign fin      = dv2_p[vsv_pkg::DIV2_CELLS];
  assign sharp_fl = (sharp_r > vsv_pkg::SHARP_FLOOR) ? sharp_r : vsv_pkg::SHARP_FLOOR;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mm[k] = fin.rsc ? {1'b0, dv2_s[vsv_pkg::DIV2_CELLS][k].quo}
                      : {1'b0, fin.m[k][22:0]};
      if (!fin.hv) begin
        smear[k] = 24'd0;
      end else if (fin.pos[k]) begin
        smear[k] = ~mm[k] + 24'd1;
      end else begin
        smear[k] = mm[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= dv2_v[vsv_pkg::DIV2_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      has_r       <= fin.hv;
      smear_r     <= smear;
      sharp_out_r <= fin.hv ? sharp_fl : 21'd0;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_has_smear     = has_r;
  assign out_smear_x       = smear_r[0];
  assign out_smear_y       = smear_r[1];
  assign out_smear_z       = smear_r[2];
  assign out_sharpness_out = sharp_out_r;

endmodule

// ===== hdl/vsv_checker.sv =====
module vsv_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_has_smear,
  input logic signed [23:0] out_smear_x,
  input logic signed [23:0] out_smear_y,
  input logic signed [23:0] out_smear_z,
  input logic        [20:0] out_sharpness_out
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // The input side stalls only behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // A missing velocity gives an all-zero transaction
  a_no_smear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_smear |->
      out_smear_x == 24'sd0 && out_smear_y == 24'sd0 && out_smear_z == 24'sd0 &&
      out_sharpness_out == 21'd0)
    else $error("nonzero fields without smear");

  // Sharpness keeps its floor
  a_sharp_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_smear |-> out_sharpness_out >= 21'd3277)
    else $error("sharpness below floor");

endmodule

bind velocity_smear_vector_top vsv_checker u_vsv_checker (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  // Scoreboard: predicts one smear result per accepted velocity and holds
  // the queue of pending results until the output side consumes them.
  class smear_board;
    typedef struct packed {
      logic        hs;
      logic [23:0] sx;
      logic [23:0] sy;
      logic [23:0] sz;
      logic [20:0] sh;
    } smear_t;

    logic [63:0] amount, stime, sharp, vmin, vmax;
    smear_t pending[$];
    int errors;

    function void reset_regs();
      amount = 64'(vsv_pkg::AMOUNT_RST);
      stime  = 64'(vsv_pkg::TIME_RST);
      sharp  = 64'(vsv_pkg::SHARP_RST);
      vmin   = 64'(vsv_pkg::MIN_SPEED_RST);
      vmax   = 64'(vsv_pkg::MAX_STRETCH_RST);
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] d);
      case (idx)
        vsv_pkg::REG_AMOUNT:      amount = 64'(d[19:0]);
        vsv_pkg::REG_TIME:        stime  = 64'(d[17:0]);
        vsv_pkg::REG_SHARP:       sharp  = 64'(d[20:0]);
        vsv_pkg::REG_MIN_SPEED:   vmin   = 64'(d[23:0]);
        vsv_pkg::REG_MAX_STRETCH: vmax   = 64'(d[22:0]);
        default: ;
      endcase
    endfunction

    function logic [63:0] root_floor(logic [63:0] n);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void note_velocity(logic vv, logic signed [24:0] vx, logic signed [24:0] vy,
                                logic signed [24:0] vz);
      smear_t e;
      logic [63:0] mag[3], sum, speed, band, x, fade, g, len;
      logic pos[3];
      logic signed [24:0] v[3];
      e = '0;
      if (vv) begin
        v[0] = vx; v[1] = vy; v[2] = vz;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
          mag[i] = v[i] < 0 ? 64'(-64'(v[i])) : 64'(v[i]);
          pos[i] = v[i] > 0;
          sum += mag[i] * mag[i];
        end
        speed = root_floor(sum);
        band = vmin > 64'(vsv_pkg::HALF_Q16) ? vmin : 64'(vsv_pkg::HALF_Q16);
        if (speed <= vmin) x = 0;
        else if (speed - vmin >= band) x = 65536;
        else x = ((speed - vmin) * 65536) / band;
        fade = (((x * x) >> 16) * (196608 - 2 * x)) >> 16;
        g = (((stime * amount) >> 16) * fade) >> 16;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
          mag[i] = (mag[i] * g) >> 16;
          sum += mag[i] * mag[i];
        end
        len = root_floor(sum);
        if (len > vmax && len > 0)
          for (int i = 0; i < 3; i++) mag[i] = (mag[i] * vmax) / len;
        e.hs = 1'b1;
        e.sx = pos[0] ? 24'(-mag[0]) : 24'(mag[0]);
        e.sy = pos[1] ? 24'(-mag[1]) : 24'(mag[1]);
        e.sz = pos[2] ? 24'(-mag[2]) : 24'(mag[2]);
        e.sh = sharp > 64'(vsv_pkg::SHARP_FLOOR) ? 21'(sharp) : vsv_pkg::SHARP_FLOOR;
      end
      pending.push_back(e);
    endfunction

    function void report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("MISMATCH %s: got %0h expected %0h", what, got, want);
    endfunction

    function void check_smear(smear_t r);
      smear_t e;
      if (pending.size() == 0) begin
        report("unexpected result", 64'(r), 64'd0);
        return;
      end
      e = pending.pop_front();
      if (r.hs !== e.hs) report("has_smear", 64'(r.hs), 64'(e.hs));
      if (r.sx !== e.sx) report("smear_x", 64'(r.sx), 64'(e.sx));
      if (r.sy !== e.sy) report("smear_y", 64'(r.sy), 64'(e.sy));
      if (r.sz !== e.sz) report("smear_z", 64'(r.sz), 64'(e.sz));
      if (r.sh !== e.sh) report("sharpness_out", 64'(r.sh), 64'(e.sh));
    endfunction
  endclass

  localparam int LATENCY = 116;
  localparam int WATCHDOG = 20000;
  localparam logic signed [24:0] VMAX = 25'sd13107200;

  logic clk, rst_n;
  logic in_valid, in_stall, in_velocity_valid;
  logic signed [24:0] in_vel_x, in_vel_y, in_vel_z;
  logic out_valid, out_stall, out_has_smear;
  logic signed [23:0] out_smear_x, out_smear_y, out_smear_z;
  logic [20:0] out_sharpness_out;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [23:0] cfg_wdata;

  smear_board board;
  int idle_cycles;
  bit hold_off_req;   // ask the receiver for one long stall stretch

  velocity_smear_vector_top i_dut (.*);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Pick a gap: mostly zero or short, now and then long.
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Receiver: stall at random, and once hold off long enough to fill the pipe.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 0;
        out_stall <= 1'b1;
        repeat (LATENCY + 60) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        int g;
        g = gap_len();
        if (g > 0) begin
          out_stall <= 1'b1;
          repeat (g) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Sample each accepted result and check it against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_smear({out_has_smear, out_smear_x, out_smear_y, out_smear_z,
                         out_sharpness_out});
  end

  // Watchdog: count cycles in which nothing moves.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Write one register; cfg_ready is sampled at the edge.
  task automatic cfg_write(logic [2:0] idx, logic [23:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, d);
    cfg_valid <= 1'b0;
  endtask

  // Offer one velocity and hold it until the block takes it.
  task automatic send_velocity(logic vv, logic signed [24:0] vx, logic signed [24:0] vy,
                               logic signed [24:0] vz, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_velocity_valid <= vv;
    in_vel_x          <= vx;
    in_vel_y          <= vy;
    in_vel_z          <= vz;
    do @(posedge clk); while (in_stall);
    board.note_velocity(vv, vx, vy, vz);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  function automatic logic signed [24:0] rand_comp(int scale);
    logic signed [24:0] v;
    v = 25'($urandom_range(scale));
    return $urandom_range(1) ? -v : v;
  endfunction

  // Random velocity: mostly in the fade band and above, some tiny, some full range.
  task automatic random_velocity(bit gaps);
    int p, s;
    p = $urandom_range(99);
    s = p < 10 ? 70000 : (p < 30 ? 13107200 : (p < 90 ? 400000 : 3000000));
    send_velocity($urandom_range(9) != 0, rand_comp(s), rand_comp(s), rand_comp(s), gaps);
  endtask

  task automatic set_all(logic [23:0] a, logic [23:0] t, logic [23:0] sh,
                         logic [23:0] mn, logic [23:0] mx);
    cfg_write(vsv_pkg::REG_AMOUNT, a);
    cfg_write(vsv_pkg::REG_TIME, t);
    cfg_write(vsv_pkg::REG_SHARP, sh);
    cfg_write(vsv_pkg::REG_MIN_SPEED, mn);
    cfg_write(vsv_pkg::REG_MAX_STRETCH, mx);
  endtask

  initial begin
    board = new();
    board.reset_regs();
    board.errors = 0;
    hold_off_req = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_velocity_valid = 1'b0;
    in_vel_x = '0;
    in_vel_y = '0;
    in_vel_z = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: missing velocity, zero, extremes, fade band edges, all signs.
    send_velocity(0, VMAX, -VMAX, VMAX, 0);
    send_velocity(1, 0, 0, 0, 0);
    send_velocity(1, VMAX, VMAX, VMAX, 0);
    send_velocity(1, -VMAX, -VMAX, -VMAX, 0);
    send_velocity(1, -25'sd16777216 + 25'sd1, 0, 0, 0);
    send_velocity(1, 25'sd131072, 0, 0, 0);
    send_velocity(1, 25'sd131073, 0, 0, 0);
    send_velocity(1, 0, 25'sd196608, 0, 0);
    send_velocity(1, 0, 0, -25'sd262144, 0);
    send_velocity(1, 25'sd300000, -25'sd100000, 25'sd50000, 0);
    send_velocity(1, 25'sd1, -25'sd1, 25'sd1, 0);
    drain();

    // Registers at extremes: zero min speed, zero stretch (rescale everything to 0).
    set_all(24'd655360, 24'd131072, 24'd0, 24'd0, 24'd0);
    send_velocity(1, 25'sd20000, 25'sd0, 25'sd0, 0);
    send_velocity(1, VMAX, -VMAX, 25'sd5, 0);
    send_velocity(1, 25'sd1, 0, 0, 0);
    send_velocity(0, 0, 0, 0, 0);
    drain();
    // Masked values above range, unknown index ignored.
    cfg_write(3'd7, 24'hFFFFFF);
    set_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd13107200, 24'hFFFFFF);
    send_velocity(1, VMAX, VMAX, -VMAX, 0);
    send_velocity(1, -VMAX, 25'sd100, 0, 0);
    drain();

    // Random phases, each with its own register setting.
    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 0) set_all(24'(vsv_pkg::AMOUNT_RST), 24'(vsv_pkg::TIME_RST),
                           24'(vsv_pkg::SHARP_RST), 24'(vsv_pkg::MIN_SPEED_RST),
                           24'(vsv_pkg::MAX_STRETCH_RST));
      else set_all(24'($urandom_range(655360)), 24'($urandom_range(131072)),
                   24'($urandom_range(1048576)), 24'($urandom_range(300000)),
                   ph == 3 ? 24'd6553600 : 24'($urandom_range(400000)));
      if (ph == 2) hold_off_req = 1;
      for (int k = 0; k < 100; k++) random_velocity(ph != 4);
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
